@@ sv/mdfc_pkg.sv @@
// Package for the depth-first maze carver: register indexes, direction codes, FSM type, helpers.
package mdfc_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd1;

  // Fixed field widths
  localparam int unsigned CFG_DATA_W = 6;
  localparam int unsigned CODE_W     = 5;
  localparam int unsigned OUT_XY_W   = 5;
  localparam int unsigned TRIED_W    = 3;

  localparam logic [CFG_DATA_W-1:0] GRID_RESET_SIZE = 6'd16;
  localparam logic [CODE_W-1:0]     CODE_COUNT      = 5'd24;
  localparam logic [TRIED_W-1:0]    TRIED_ALL       = 3'd4;

  // Wall / direction codes
  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_TRY   = 6'b000100,
    S_CHECK = 6'b001000,
    S_LOAD  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  // Direction at position pos of a lexicographic permutation code (0..23).
  // Digits are radix 6, 2, 1; each pick removes the chosen entry from the list.
  function automatic dir_t perm_dir(input logic [CODE_W-1:0] code, input logic [1:0] pos);
    logic [1:0] avail [4];
    logic [1:0] k     [4];
    logic [CODE_W-1:0] rem;
    logic [1:0] pick;
    avail[0] = 2'd0;
    avail[1] = 2'd1;
    avail[2] = 2'd2;
    avail[3] = 2'd3;
    // first digit by compare chain
    if (code >= 5'd18) begin
      k[0] = 2'd3;
      rem  = code - 5'd18;
    end else if (code >= 5'd12) begin
      k[0] = 2'd2;
      rem  = code - 5'd12;
    end else if (code >= 5'd6) begin
      k[0] = 2'd1;
      rem  = code - 5'd6;
    end else begin
      k[0] = 2'd0;
      rem  = code;
    end
    if (rem >= 5'd4) begin
      k[1] = 2'd2;
    end else if (rem >= 5'd2) begin
      k[1] = 2'd1;
    end else begin
      k[1] = 2'd0;
    end
    k[2] = {1'b0, rem[0]};
    k[3] = 2'd0;
    pick = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (i <= int'(pos)) begin
        pick = avail[k[i]];
        for (int j = 0; j < 3; j++) begin
          if (j >= int'(k[i])) begin
            avail[j] = avail[j+1];
          end
        end
      end
    end
    return dir_t'(pick);
  endfunction

endpackage

@@ sv/mdfc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mdfc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/maze_depth_first_carver.sv @@
// Depth-first maze carver: frame stack walk with a visited map, one result per transaction.
//
//  Channel | Ports                                              | Dir | Handshake
//  --------+----------------------------------------------------+-----+---------------------
//  cfg     | cfg_we, cfg_index, cfg_data                        | in  | write when cfg_we
//  in      | in_valid, in_stall, in_order_code                  | in  | valid && !stall
//  out     | out_valid, out_stall, out_cell_x/_y, out_wall_side,| out | valid && !stall
//          | out_maze_done                                      |     |
//
// A transaction enters the cell (S_IDLE), then tries its directions in S_TRY: a direction that
// leaves the grid is skipped, an in-grid one reads the visited RAM (S_CHECK), and an exhausted
// frame is popped by a stack RAM read (S_LOAD) unless it is the bottom frame, which ends the
// walk; S_EMIT then hands the result to the output register.
// After reset and after every done result the visited map is swept, one entry a cycle, over
// all 2^(XW+YW) entries (1024 at the default size), with in_stall high throughout.
// Reset is synchronous, active low. out_stall holds the result in the output register;
// the sequencer waits for it before loading the next one. Config writes are taken any time.
module maze_depth_first_carver #(
  parameter int unsigned MAX_WIDTH  = 32,
  parameter int unsigned MAX_HEIGHT = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mdfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mdfc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mdfc_pkg::CODE_W-1:0]     in_order_code,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mdfc_pkg::OUT_XY_W-1:0]   out_cell_x,
  output logic [mdfc_pkg::OUT_XY_W-1:0]   out_cell_y,
  output logic [1:0]                      out_wall_side,
  output logic                            out_maze_done
);

  // Derived widths
  localparam int unsigned XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned VAW   = XW + YW;
  localparam int unsigned VDEPTH = 1 << VAW;
  localparam int unsigned CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned SAW   = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned DPW   = $clog2(CELLS + 1);
  localparam int unsigned SW0   = ($clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1)) ?
                                  $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
  localparam int unsigned SZW   = (SW0 > mdfc_pkg::CFG_DATA_W) ? SW0 : mdfc_pkg::CFG_DATA_W;
  localparam int unsigned FW    = XW + YW + mdfc_pkg::CODE_W + mdfc_pkg::TRIED_W;

  localparam logic [SZW-1:0] MAXW_S   = SZW'(MAX_WIDTH);
  localparam logic [SZW-1:0] MAXH_S   = SZW'(MAX_HEIGHT);
  localparam logic [DPW-1:0] CELLS_D  = DPW'(CELLS);
  localparam logic [VAW-1:0] VLAST    = VAW'(VDEPTH - 1);

  // State
  mdfc_pkg::state_t state_r, state_nxt;
  logic [mdfc_pkg::CFG_DATA_W-1:0] grid_width_r, grid_height_r;
  logic [DPW-1:0]   depth_r, depth_nxt;
  logic [XW-1:0]    next_x_r, next_x_nxt;
  logic [YW-1:0]    next_y_r, next_y_nxt;
  logic [XW-1:0]    top_x_r, top_x_nxt;
  logic [YW-1:0]    top_y_r, top_y_nxt;
  logic [mdfc_pkg::CODE_W-1:0]  top_code_r, top_code_nxt;
  logic [mdfc_pkg::TRIED_W-1:0] top_tried_r, top_tried_nxt;
  logic [XW-1:0]    nb_x_r, nb_x_nxt;
  logic [YW-1:0]    nb_y_r, nb_y_nxt;
  mdfc_pkg::dir_t   nb_dir_r, nb_dir_nxt;
  logic [VAW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic             res_done_r, res_done_nxt;

  // Output register
  logic                          out_valid_r, out_valid_nxt;
  logic [mdfc_pkg::OUT_XY_W-1:0] out_x_r, out_x_nxt;
  logic [mdfc_pkg::OUT_XY_W-1:0] out_y_r, out_y_nxt;
  logic [1:0]                    out_side_r, out_side_nxt;
  logic                          out_done_r, out_done_nxt;

  // Combinational helpers
  logic [SZW-1:0]   w_raw, h_raw, w_eff, h_eff;
  logic [mdfc_pkg::CODE_W-1:0] code_red;
  mdfc_pkg::dir_t   try_dir;
  logic             dir_ok, nb_ok;
  logic [XW-1:0]    nb_x_c;
  logic [YW-1:0]    nb_y_c;
  logic             in_acc, out_free;

  // RAM ports
  logic             vis_we;
  logic [VAW-1:0]   vis_waddr;
  logic             vis_wdata;
  logic             vis_rdata;
  logic             stk_we;
  logic [SAW-1:0]   stk_waddr, stk_raddr;
  logic [FW-1:0]    stk_wdata, stk_rdata;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Grid size clamp to 1..MAX
  assign w_raw = SZW'(grid_width_r);
  assign h_raw = SZW'(grid_height_r);
  assign w_eff = (w_raw == '0) ? SZW'(1) : ((w_raw > MAXW_S) ? MAXW_S : w_raw);
  assign h_eff = (h_raw == '0) ? SZW'(1) : ((h_raw > MAXH_S) ? MAXH_S : h_raw);

  // Codes past the last permutation wrap once
  assign code_red = (in_order_code >= mdfc_pkg::CODE_COUNT) ?
                    (in_order_code - mdfc_pkg::CODE_COUNT) : in_order_code;

  // Neighbor of the top frame in the direction under trial
  assign try_dir = mdfc_pkg::perm_dir(top_code_r, top_tried_r[1:0]);

  always_comb begin
    nb_x_c = top_x_r;
    nb_y_c = top_y_r;
    dir_ok = 1'b0;
    case (try_dir)
      mdfc_pkg::DIR_UP: begin
        dir_ok = (top_y_r != '0);
        nb_y_c = top_y_r - YW'(1);
      end
      mdfc_pkg::DIR_DOWN: begin
        dir_ok = ((SZW'(top_y_r) + SZW'(1)) < h_eff);
        nb_y_c = top_y_r + YW'(1);
      end
      mdfc_pkg::DIR_LEFT: begin
        dir_ok = (top_x_r != '0);
        nb_x_c = top_x_r - XW'(1);
      end
      mdfc_pkg::DIR_RIGHT: begin
        dir_ok = ((SZW'(top_x_r) + SZW'(1)) < w_eff);
        nb_x_c = top_x_r + XW'(1);
      end
      default: begin
        dir_ok = 1'b0;
      end
    endcase
    nb_ok = dir_ok && (SZW'(nb_x_c) < w_eff) && (SZW'(nb_y_c) < h_eff);
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    depth_nxt     = depth_r;
    next_x_nxt    = next_x_r;
    next_y_nxt    = next_y_r;
    top_x_nxt     = top_x_r;
    top_y_nxt     = top_y_r;
    top_code_nxt  = top_code_r;
    top_tried_nxt = top_tried_r;
    nb_x_nxt      = nb_x_r;
    nb_y_nxt      = nb_y_r;
    nb_dir_nxt    = nb_dir_r;
    clr_cnt_nxt   = clr_cnt_r;
    res_done_nxt  = res_done_r;
    vis_we        = 1'b0;
    vis_waddr     = {next_y_r, next_x_r};
    vis_wdata     = 1'b1;
    stk_we        = 1'b0;
    stk_waddr     = SAW'(depth_r - DPW'(1));
    stk_wdata     = {top_x_r, top_y_r, top_code_r, top_tried_r};
    stk_raddr     = SAW'(depth_r - DPW'(2));
    out_valid_nxt = out_valid_r && out_stall;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_side_nxt  = out_side_r;
    out_done_nxt  = out_done_r;

    case (state_r)
      // sweep the visited map to zero
      mdfc_pkg::S_CLEAR: begin
        vis_we      = 1'b1;
        vis_waddr   = clr_cnt_r;
        vis_wdata   = 1'b0;
        clr_cnt_nxt = clr_cnt_r + VAW'(1);
        if (clr_cnt_r == VLAST) begin
          state_nxt = mdfc_pkg::S_IDLE;
        end
      end
      // enter the next cell: mark it and push its frame
      mdfc_pkg::S_IDLE: begin
        if (in_acc) begin
          vis_we = 1'b1;
          if (depth_r < CELLS_D) begin
            stk_we        = (depth_r != '0);
            top_x_nxt     = next_x_r;
            top_y_nxt     = next_y_r;
            top_code_nxt  = code_red;
            top_tried_nxt = '0;
            depth_nxt     = depth_r + DPW'(1);
          end
          state_nxt = mdfc_pkg::S_TRY;
        end
      end
      // try one direction, or pop an exhausted frame
      mdfc_pkg::S_TRY: begin
        if (top_tried_r == mdfc_pkg::TRIED_ALL || depth_r == '0) begin
          if (depth_r <= DPW'(1)) begin
            depth_nxt    = '0;
            next_x_nxt   = '0;
            next_y_nxt   = '0;
            res_done_nxt = 1'b1;
            state_nxt    = mdfc_pkg::S_EMIT;
          end else begin
            depth_nxt = depth_r - DPW'(1);
            state_nxt = mdfc_pkg::S_LOAD;
          end
        end else begin
          top_tried_nxt = top_tried_r + mdfc_pkg::TRIED_W'(1);
          if (nb_ok) begin
            nb_x_nxt   = nb_x_c;
            nb_y_nxt   = nb_y_c;
            nb_dir_nxt = try_dir;
            state_nxt  = mdfc_pkg::S_CHECK;
          end
        end
      end
      // visited bit of the neighbor is back
      mdfc_pkg::S_CHECK: begin
        if (!vis_rdata) begin
          next_x_nxt   = nb_x_r;
          next_y_nxt   = nb_y_r;
          res_done_nxt = 1'b0;
          state_nxt    = mdfc_pkg::S_EMIT;
        end else begin
          state_nxt = mdfc_pkg::S_TRY;
        end
      end
      // frame below the popped one is back
      mdfc_pkg::S_LOAD: begin
        {top_x_nxt, top_y_nxt, top_code_nxt, top_tried_nxt} = stk_rdata;
        state_nxt = mdfc_pkg::S_TRY;
      end
      // hand the result to the output register
      mdfc_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_done_nxt  = res_done_r;
          if (res_done_r) begin
            out_x_nxt    = '0;
            out_y_nxt    = '0;
            out_side_nxt = '0;
            clr_cnt_nxt  = '0;
            state_nxt    = mdfc_pkg::S_CLEAR;
          end else begin
            out_x_nxt    = mdfc_pkg::OUT_XY_W'(top_x_r);
            out_y_nxt    = mdfc_pkg::OUT_XY_W'(top_y_r);
            out_side_nxt = nb_dir_r;
            state_nxt    = mdfc_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = mdfc_pkg::S_CLEAR;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= mdfc_pkg::S_CLEAR;
      clr_cnt_r     <= '0;
      depth_r       <= '0;
      next_x_r      <= '0;
      next_y_r      <= '0;
      out_valid_r   <= 1'b0;
      grid_width_r  <= mdfc_pkg::GRID_RESET_SIZE;
      grid_height_r <= mdfc_pkg::GRID_RESET_SIZE;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      depth_r     <= depth_nxt;
      next_x_r    <= next_x_nxt;
      next_y_r    <= next_y_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == mdfc_pkg::CFG_GRID_WIDTH) begin
        grid_width_r <= cfg_data;
      end
      if (cfg_we && cfg_index == mdfc_pkg::CFG_GRID_HEIGHT) begin
        grid_height_r <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    top_x_r     <= top_x_nxt;
    top_y_r     <= top_y_nxt;
    top_code_r  <= top_code_nxt;
    top_tried_r <= top_tried_nxt;
    nb_x_r      <= nb_x_nxt;
    nb_y_r      <= nb_y_nxt;
    nb_dir_r    <= nb_dir_nxt;
    res_done_r  <= res_done_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_side_r  <= out_side_nxt;
    out_done_r  <= out_done_nxt;
  end

  // Visited map, one bit per cell
  mdfc_ram #(
    .WIDTH (1),
    .DEPTH (VDEPTH)
  ) u_visited (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_waddr),
    .wdata (vis_wdata),
    .raddr ({nb_y_c, nb_x_c}),
    .rdata (vis_rdata)
  );

  // Frame stack below the cached top frame
  mdfc_ram #(
    .WIDTH (FW),
    .DEPTH (CELLS)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign in_stall      = (state_r != mdfc_pkg::S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_cell_x    = out_x_r;
  assign out_cell_y    = out_y_r;
  assign out_wall_side = out_side_r;
  assign out_maze_done = out_done_r;

  // Checks
  a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mdfc_pkg::S_CLEAR) |-> in_stall)
    else $error("input taken during visited-map sweep");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= CELLS_D)
    else $error("frame stack overflow");

  a_push_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && depth_r < CELLS_D) |=> (depth_r == $past(depth_r) + DPW'(1)))
    else $error("push did not grow the stack");

  a_tried_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mdfc_pkg::S_TRY) |-> (top_tried_r <= mdfc_pkg::TRIED_ALL))
    else $error("top frame tried count out of range");

  a_done_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_maze_done) |->
      (out_cell_x == '0 && out_cell_y == '0 && out_wall_side == '0))
    else $error("done result carries a wall");

endmodule

@@ dv/maze_depth_first_carver_tb.sv @@
// Self-checking testbench for the depth-first maze carver: directed and random walks.
`timescale 1ns / 100ps

module maze_depth_first_carver_tb;

  localparam int unsigned GRID_MAX     = 32;
  localparam int unsigned CELLS        = GRID_MAX * GRID_MAX;
  localparam int unsigned ORDER_TARGET = 1650;
  localparam int unsigned IDLE_LIMIT   = 8000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned REPORT_MAX   = 10;

  // One carve result: a wall removal or the end-of-walk marker
  typedef struct packed {
    logic [mdfc_pkg::OUT_XY_W-1:0] x;
    logic [mdfc_pkg::OUT_XY_W-1:0] y;
    mdfc_pkg::dir_t                side;
    logic                          done;
  } carve_t;

  // Walk predictor and queue of expected carves
  class carver_scoreboard;
    logic [mdfc_pkg::CFG_DATA_W-1:0] width_reg;
    logic [mdfc_pkg::CFG_DATA_W-1:0] height_reg;
    bit                              visited [CELLS];
    logic [mdfc_pkg::OUT_XY_W-1:0]   frm_x [CELLS];
    logic [mdfc_pkg::OUT_XY_W-1:0]   frm_y [CELLS];
    logic [mdfc_pkg::CODE_W-1:0]     frm_code [CELLS];
    int unsigned                     frm_tried [CELLS];
    int unsigned                     depth;
    logic [mdfc_pkg::OUT_XY_W-1:0]   next_x;
    logic [mdfc_pkg::OUT_XY_W-1:0]   next_y;
    carve_t                          expected_carves [$];
    int unsigned                     mismatches;

    function new();
      width_reg  = mdfc_pkg::GRID_RESET_SIZE;
      height_reg = mdfc_pkg::GRID_RESET_SIZE;
      depth      = 0;
      next_x     = '0;
      next_y     = '0;
      mismatches = 0;
      foreach (visited[i]) visited[i] = 1'b0;
    endfunction

    function void set_reg(logic [mdfc_pkg::CFG_IDX_W-1:0] idx,
                          logic [mdfc_pkg::CFG_DATA_W-1:0] val);
      if (idx == mdfc_pkg::CFG_GRID_WIDTH) begin
        width_reg = val;
      end else begin
        height_reg = val;
      end
    endfunction

    // zero acts as one, oversize saturates
    function int unsigned span(logic [mdfc_pkg::CFG_DATA_W-1:0] val);
      if (val == 0) return 1;
      if (val > GRID_MAX) return GRID_MAX;
      return 32'(val);
    endfunction

    // direction at slot pos of a lexicographic order code (code below 24)
    function mdfc_pkg::dir_t order_dir(logic [mdfc_pkg::CODE_W-1:0] code, int unsigned pos);
      mdfc_pkg::dir_t pool [4];
      int unsigned    digit [4];
      int unsigned    k;
      mdfc_pkg::dir_t pick;
      pool[0] = mdfc_pkg::DIR_UP;
      pool[1] = mdfc_pkg::DIR_DOWN;
      pool[2] = mdfc_pkg::DIR_LEFT;
      pool[3] = mdfc_pkg::DIR_RIGHT;
      digit[0] = code / 6;
      digit[1] = (code % 6) / 2;
      digit[2] = code % 2;
      digit[3] = 0;
      pick = mdfc_pkg::DIR_UP;
      for (int i = 0; i <= int'(pos); i++) begin
        k = digit[i];
        pick = pool[k];
        for (int j = int'(k); j < 3; j++) pool[j] = pool[j+1];
      end
      return pick;
    endfunction

    // enter the next cell with this order code and predict the carve it causes
    function void take_order(logic [mdfc_pkg::CODE_W-1:0] raw_code);
      logic [mdfc_pkg::CODE_W-1:0] code;
      int unsigned                 w, h, top, cx, cy;
      int                          nx, ny;
      mdfc_pkg::dir_t              d;
      bit                          ok;
      carve_t                      c;
      code = (raw_code >= mdfc_pkg::CODE_COUNT) ? raw_code - mdfc_pkg::CODE_COUNT : raw_code;
      w  = span(width_reg);
      h  = span(height_reg);
      cx = 32'(next_x);
      cy = 32'(next_y);
      visited[cy * GRID_MAX + cx] = 1'b1;
      if (depth < CELLS) begin
        frm_x[depth]     = mdfc_pkg::OUT_XY_W'(cx);
        frm_y[depth]     = mdfc_pkg::OUT_XY_W'(cy);
        frm_code[depth]  = code;
        frm_tried[depth] = 0;
        depth++;
      end
      // backtrack until some frame still has an open neighbour
      while (depth > 0) begin
        top = depth - 1;
        while (frm_tried[top] < 4) begin
          d = order_dir(frm_code[top], frm_tried[top]);
          frm_tried[top]++;
          nx = int'(frm_x[top]);
          ny = int'(frm_y[top]);
          ok = 1'b0;
          case (d)
            mdfc_pkg::DIR_UP: begin
              if (ny > 0) begin ny--; ok = 1'b1; end
            end
            mdfc_pkg::DIR_DOWN: begin
              if (ny + 1 < int'(h)) begin ny++; ok = 1'b1; end
            end
            mdfc_pkg::DIR_LEFT: begin
              if (nx > 0) begin nx--; ok = 1'b1; end
            end
            default: begin
              if (nx + 1 < int'(w)) begin nx++; ok = 1'b1; end
            end
          endcase
          if (ok && nx < int'(w) && ny < int'(h) && !visited[ny * GRID_MAX + nx]) begin
            next_x = mdfc_pkg::OUT_XY_W'(nx);
            next_y = mdfc_pkg::OUT_XY_W'(ny);
            c.x    = frm_x[top];
            c.y    = frm_y[top];
            c.side = d;
            c.done = 1'b0;
            expected_carves.push_back(c);
            return;
          end
        end
        depth--;
      end
      // walk finished: fresh maze from (0,0)
      foreach (visited[i]) visited[i] = 1'b0;
      depth  = 0;
      next_x = '0;
      next_y = '0;
      c.x    = '0;
      c.y    = '0;
      c.side = mdfc_pkg::DIR_UP;
      c.done = 1'b1;
      expected_carves.push_back(c);
    endfunction

    function void check_wall(logic [mdfc_pkg::OUT_XY_W-1:0] x,
                             logic [mdfc_pkg::OUT_XY_W-1:0] y,
                             logic [1:0] side, logic done);
      carve_t e;
      if (expected_carves.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: unexpected carve x=%0d y=%0d side=%0d done=%0b",
                   $realtime, x, y, side, done);
        return;
      end
      e = expected_carves.pop_front();
      if (x !== e.x || y !== e.y || side !== e.side || done !== e.done) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: carve mismatch exp x=%0d y=%0d side=%0d done=%0b, %s",
                   $realtime, e.x, e.y, e.side, e.done,
                   $sformatf("got x=%0d y=%0d side=%0d done=%0b", x, y, side, done));
      end
    endfunction

    function int unsigned pending();
      return expected_carves.size();
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [mdfc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [mdfc_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            in_valid;
  logic                            in_stall;
  logic [mdfc_pkg::CODE_W-1:0]     in_order_code;
  logic                            out_valid;
  logic                            out_stall;
  logic [mdfc_pkg::OUT_XY_W-1:0]   out_cell_x;
  logic [mdfc_pkg::OUT_XY_W-1:0]   out_cell_y;
  logic [1:0]                      out_wall_side;
  logic                            out_maze_done;

  carver_scoreboard sb;
  bit               hold_req;
  bit               hold_active;
  int unsigned      orders_sent;
  int unsigned      idle_cycles;

  maze_depth_first_carver uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_order_code (in_order_code),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_cell_x    (out_cell_x),
    .out_cell_y    (out_cell_y),
    .out_wall_side (out_wall_side),
    .out_maze_done (out_maze_done)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Transaction monitors feed the scoreboard
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.take_order(in_order_code);
    if (rst_n && out_valid && !out_stall)
      sb.check_wall(out_cell_x, out_cell_y, out_wall_side, out_maze_done);
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin : rx_side
    int unsigned len;
    bit          held;
    held        = 1'b0;
    hold_active = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held        = 1'b1;
        out_stall   <= 1'b1;
        hold_active = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_active = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
        out_stall <= 1'b1;
        repeat (len) @(posedge clk);
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 100) : $urandom_range(1, 12);
        out_stall <= 1'b0;
        repeat (len) @(posedge clk);
      end
    end
  end

  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 50);
  endfunction

  function automatic logic [mdfc_pkg::CODE_W-1:0] rand_code();
    if ($urandom_range(0, 9) == 0) return mdfc_pkg::CODE_W'($urandom_range(24, 31));
    return mdfc_pkg::CODE_W'($urandom_range(0, 23));
  endfunction

  // mostly small grids so walks finish often; a few zero or oversize values
  function automatic logic [mdfc_pkg::CFG_DATA_W-1:0] rand_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return mdfc_pkg::CFG_DATA_W'($urandom_range(1, 6));
    if (r < 88) return mdfc_pkg::CFG_DATA_W'($urandom_range(7, 32));
    if (r < 94) return '0;
    return mdfc_pkg::CFG_DATA_W'($urandom_range(33, 63));
  endfunction

  // Offer one order code; valid stays high when no gap follows
  task automatic send_order(input logic [mdfc_pkg::CODE_W-1:0] code, input int unsigned gap);
    in_valid      <= 1'b1;
    in_order_code <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    orders_sent++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_list(input logic [mdfc_pkg::CODE_W-1:0] codes [$]);
    foreach (codes[i]) send_order(codes[i], rand_gap());
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Register writes; only issued while nothing is outstanding
  task automatic write_grid(input bit do_w, input logic [mdfc_pkg::CFG_DATA_W-1:0] w,
                            input bit do_h, input logic [mdfc_pkg::CFG_DATA_W-1:0] h);
    if (do_w) begin
      cfg_we    <= 1'b1;
      cfg_index <= mdfc_pkg::CFG_GRID_WIDTH;
      cfg_data  <= w;
      @(posedge clk);
      sb.set_reg(mdfc_pkg::CFG_GRID_WIDTH, w);
    end
    if (do_h) begin
      cfg_we    <= 1'b1;
      cfg_index <= mdfc_pkg::CFG_GRID_HEIGHT;
      cfg_data  <= h;
      @(posedge clk);
      sb.set_reg(mdfc_pkg::CFG_GRID_HEIGHT, h);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin : main_seq
    int unsigned phase, n, errors, sel;
    sb            = new();
    hold_req      = 1'b0;
    orders_sent   = 0;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= mdfc_pkg::CFG_GRID_WIDTH;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    in_order_code <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Default 16x16 grid, code extremes and the folded codes above 23
    send_list('{5'd0, 5'd23, 5'd31, 5'd24, 5'd7, 5'd16});
    wait_drained();
    // Zero sizes act as 1x1: the pending cell lies outside, then a lone cell
    write_grid(1'b1, 6'd0, 1'b1, 6'd0);
    send_list('{5'd3, 5'd29});
    wait_drained();
    // Oversize width saturates: a 32x1 corridor walked to the right
    write_grid(1'b1, 6'd63, 1'b1, 6'd1);
    send_list('{5'd0, 5'd12, 5'd23, 5'd31, 5'd5, 5'd18});
    wait_drained();
    // Shrink mid-walk: next cell is entered outside the grid and the walk unwinds
    write_grid(1'b1, 6'd2, 1'b0, 6'd0);
    send_list('{5'd9});
    wait_drained();
    write_grid(1'b1, 6'd1, 1'b1, 6'd32);
    send_list('{5'd0, 5'd1, 5'd2, 5'd3});
    wait_drained();
    write_grid(1'b1, 6'd33, 1'b1, 6'd2);
    send_list('{5'd4, 5'd30, 5'd11, 5'd20});
    wait_drained();

    // Random phases, sometimes resizing mid-walk
    phase = 0;
    while (orders_sent < ORDER_TARGET) begin
      sel = $urandom_range(0, 7);
      if (sel < 4) write_grid(1'b1, rand_size(), 1'b1, rand_size());
      else if (sel == 4) write_grid(1'b1, rand_size(), 1'b0, '0);
      else if (sel == 5) write_grid(1'b0, '0, 1'b1, rand_size());
      n = $urandom_range(10, 80);
      if (phase == 1) begin
        // receiver holds off while the sender keeps offering back to back
        hold_req = 1'b1;
        wait (hold_active);
        repeat (n) send_order(rand_code(), 0);
      end else begin
        repeat (n) send_order(rand_code(), rand_gap());
      end
      in_valid <= 1'b0;
      wait_drained();
      phase++;
    end

    repeat (40) @(posedge clk);
    errors = sb.mismatches + sb.pending();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
